@@ rtl/tlcf_pkg.sv @@
// Shared types, constants and the control store for the two-layer color fade.
// Used by the channel interfaces, the sequencer, the datapath and the top level.
package tlcf_pkg;

  // fixed field widths of the channels
  localparam int FIELD_W  = 17;
  localparam int FRAMES_W = 16;

  localparam int LAYER_COUNT_DEF   = 2;
  localparam int FRACTION_BITS_DEF = 16;

  localparam int CH_COUNT = 4;
  localparam logic [1:0] CH_ALPHA = 2'd3;
  localparam logic [1:0] CH_LAST  = 2'd3;

  // fade kinds
  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_IN   = 2'd1;
  localparam logic [1:0] KIND_OUT  = 2'd2;
  localparam logic [1:0] KIND_STAY = 2'd3;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_BEGIN,
    OP_DIV_LOAD,
    OP_DIV_STEP,
    OP_DIV_STORE,
    OP_CHECK,
    OP_ADD,
    OP_NEXT_LAYER,
    OP_EMIT
  } op_e;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_VALID,
    C_IS_TICK,
    C_DIV_MORE,
    C_CH_MORE,
    C_START_MORE,
    C_LY_MORE,
    C_OUT_BUSY
  } cond_e;

  localparam int UPC_W    = 4;
  localparam int PROG_LEN = 13;

  // control store addresses
  localparam logic [UPC_W-1:0] UA_WAIT       = 4'd0;
  localparam logic [UPC_W-1:0] UA_DISPATCH   = 4'd1;
  localparam logic [UPC_W-1:0] UA_BEGIN      = 4'd2;
  localparam logic [UPC_W-1:0] UA_DIV_LOAD   = 4'd3;
  localparam logic [UPC_W-1:0] UA_DIV_STEP   = 4'd4;
  localparam logic [UPC_W-1:0] UA_DIV_STORE  = 4'd5;
  localparam logic [UPC_W-1:0] UA_START_NEXT = 4'd6;
  localparam logic [UPC_W-1:0] UA_START_END  = 4'd7;
  localparam logic [UPC_W-1:0] UA_CHECK      = 4'd8;
  localparam logic [UPC_W-1:0] UA_ADD        = 4'd9;
  localparam logic [UPC_W-1:0] UA_TICK_NEXT  = 4'd10;
  localparam logic [UPC_W-1:0] UA_EMIT       = 4'd11;
  localparam logic [UPC_W-1:0] UA_RETURN     = 4'd12;

  typedef struct packed {
    op_e              op;
    cond_e            cond;
    logic [UPC_W-1:0] target;
  } uword_t;

  // datapath flags seen by the sequencer
  typedef struct packed {
    logic in_valid;
    logic is_tick;
    logic div_more;
    logic ch_more;
    logic start_more;
    logic ly_more;
    logic out_busy;
  } seq_status_t;

  // control store: the branch is taken when the condition holds,
  // otherwise the program falls through to the next word
  function automatic uword_t ucode(input logic [UPC_W-1:0] pc);
    uword_t w;
    w = '{op: OP_NOP, cond: C_ALWAYS, target: UA_WAIT};
    case (pc)
      UA_WAIT:       w = '{op: OP_ACCEPT,     cond: C_NO_VALID,   target: UA_WAIT};
      UA_DISPATCH:   w = '{op: OP_NOP,        cond: C_IS_TICK,    target: UA_CHECK};
      UA_BEGIN:      w = '{op: OP_BEGIN,      cond: C_NEVER,      target: UA_WAIT};
      UA_DIV_LOAD:   w = '{op: OP_DIV_LOAD,   cond: C_NEVER,      target: UA_WAIT};
      UA_DIV_STEP:   w = '{op: OP_DIV_STEP,   cond: C_DIV_MORE,   target: UA_DIV_STEP};
      UA_DIV_STORE:  w = '{op: OP_DIV_STORE,  cond: C_CH_MORE,    target: UA_DIV_LOAD};
      UA_START_NEXT: w = '{op: OP_NEXT_LAYER, cond: C_START_MORE, target: UA_BEGIN};
      UA_START_END:  w = '{op: OP_NOP,        cond: C_ALWAYS,     target: UA_EMIT};
      UA_CHECK:      w = '{op: OP_CHECK,      cond: C_NEVER,      target: UA_WAIT};
      UA_ADD:        w = '{op: OP_ADD,        cond: C_CH_MORE,    target: UA_ADD};
      UA_TICK_NEXT:  w = '{op: OP_NEXT_LAYER, cond: C_LY_MORE,    target: UA_CHECK};
      UA_EMIT:       w = '{op: OP_EMIT,       cond: C_OUT_BUSY,   target: UA_EMIT};
      UA_RETURN:     w = '{op: OP_NOP,        cond: C_ALWAYS,     target: UA_WAIT};
      default:       w = '{op: OP_NOP,        cond: C_ALWAYS,     target: UA_WAIT};
    endcase
    return w;
  endfunction

endpackage

@@ rtl/tlcf_in_if.sv @@
// Input channel of the color fade: valid/ready handshake and one command item.
// Field widths come from tlcf_pkg.
interface tlcf_in_if import tlcf_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                mode;
  logic [1:0]          fade_kind;
  logic [1:0]          layer_select;
  logic [FRAMES_W-1:0] frames;
  logic [FIELD_W-1:0]  target_red;
  logic [FIELD_W-1:0]  target_green;
  logic [FIELD_W-1:0]  target_blue;
  logic [FIELD_W-1:0]  target_alpha;

  modport source (
    output valid, mode, fade_kind, layer_select, frames,
    output target_red, target_green, target_blue, target_alpha,
    input  ready
  );
  modport sink (
    input  valid, mode, fade_kind, layer_select, frames,
    input  target_red, target_green, target_blue, target_alpha,
    output ready
  );
endinterface

@@ rtl/tlcf_out_if.sv @@
// Output channel of the color fade: valid/ready handshake and both layer colors.
// Field widths come from tlcf_pkg.
interface tlcf_out_if import tlcf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] front_red;
  logic [FIELD_W-1:0] front_green;
  logic [FIELD_W-1:0] front_blue;
  logic [FIELD_W-1:0] front_alpha;
  logic [FIELD_W-1:0] back_red;
  logic [FIELD_W-1:0] back_green;
  logic [FIELD_W-1:0] back_blue;
  logic [FIELD_W-1:0] back_alpha;
  logic               front_visible;
  logic               back_visible;

  modport source (
    output valid, front_red, front_green, front_blue, front_alpha,
    output back_red, back_green, back_blue, back_alpha,
    output front_visible, back_visible,
    input  ready
  );
  modport sink (
    input  valid, front_red, front_green, front_blue, front_alpha,
    input  back_red, back_green, back_blue, back_alpha,
    input  front_visible, back_visible,
    output ready
  );
endinterface

@@ rtl/two_layer_color_fade.sv @@
// Two-layer linear color fade, top level.
// Uses tlcf_pkg, tlcf_in_if, tlcf_out_if, tlcf_useq, tlcf_dpath (with tlcf_div).
//
// Usage:
//   in_i carries one command per transfer. mode 1 starts a fade on one layer
//   (layer_select below LAYER_COUNT) or on all layers; mode 0 is a frame tick.
//   out_o returns one result per command: both layer colors (17-bit unsigned,
//   FRACTION_BITS fraction bits) and the visible flags, as they stand after it.
// Sequence (L = layers touched, NW = max(FRACTION_BITS + 1, 17)):
//   start: for each of the L layers touched, set up the fade, then for each
//          channel load the serial divider, run it over NW quotient bits
//          (one quotient bit per cycle, four channel steps per layer) and
//          store the step; then the result is emitted.
//   tick:  per layer, one end-of-fade check and one add per channel, then emit.
//   Items are handled one at a time; the next command is taken after the
//   result is loaded, once the sequencer is back at its wait step.
// The result sits in an output register; the next command is taken while it
// waits. If the receiver still stalls when the next result is ready, the
// sequencer holds on its emit step and takes no input until the transfer.
// Reset (async, active low): colors black with alpha 1.0, steps 0, goal
// alpha 1.0, no fade, layers hidden; the input is ready in the first cycle.
module two_layer_color_fade import tlcf_pkg::*; #(
  parameter int LAYER_COUNT   = LAYER_COUNT_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tlcf_in_if.sink    in_i,
  tlcf_out_if.source out_o
);

  op_e         op;
  seq_status_t status;

  // microcoded control: one word per step, branch on datapath flags
  tlcf_useq u_useq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .op_o     (op)
  );

  // layer state, shared divider, clamp adder and output register
  tlcf_dpath #(
    .LAYER_COUNT   (LAYER_COUNT),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dpath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .op_i     (op),
    .status_o (status),
    .in_i     (in_i),
    .out_o    (out_o)
  );

endmodule

@@ rtl/tlcf_div.sv @@
// Restoring serial divider, one quotient bit per cycle while step_i is high, unsigned operands.
// Depends on nothing but its parameters.
module tlcf_div #(
  parameter int NW  = 17,
  parameter int DVW = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  logic           step_i,
  input  logic [NW-1:0]  dividend_i,
  input  logic [DVW-1:0] divisor_i,
  output logic [NW-1:0]  quot_o,
  output logic           more_o
);

  localparam int CNT_W = $clog2(NW + 1);

  logic [DVW-1:0]   rem_q;
  logic [DVW-1:0]   dvs_q;
  logic [NW-1:0]    quo_q;
  logic [CNT_W-1:0] cnt_q;

  logic [DVW:0]   shifted;
  logic [DVW:0]   trial;
  logic           ge;
  logic [DVW-1:0] rem_d;

  always_comb begin
    shifted = {rem_q, quo_q[NW-1]};
    trial   = shifted - {1'b0, dvs_q};
    ge      = (shifted >= {1'b0, dvs_q});
    rem_d   = ge ? trial[DVW-1:0] : shifted[DVW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      dvs_q <= '0;
      quo_q <= '0;
      cnt_q <= '0;
    end else if (load_i) begin
      rem_q <= '0;
      dvs_q <= divisor_i;
      quo_q <= dividend_i;
      cnt_q <= CNT_W'(NW);
    end else if (step_i) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[NW-2:0], ge};
      cnt_q <= cnt_q - CNT_W'(1);
    end
  end

  assign quot_o = quo_q;
  assign more_o = (cnt_q > CNT_W'(1));

  // a step past the last quotient bit would corrupt the result
  a_no_extra_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i |-> (cnt_q != '0))
    else $error("divider stepped with no bits left");

endmodule

@@ rtl/tlcf_dpath.sv @@
// Datapath of the color fade: layer state, item latch, divider, clamp adder
// and the output register. Driven by the op field from tlcf_useq; uses tlcf_pkg.
module tlcf_dpath import tlcf_pkg::*; #(
  parameter int LAYER_COUNT   = LAYER_COUNT_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  op_e         op_i,
  output seq_status_t status_o,
  tlcf_in_if.sink     in_i,
  tlcf_out_if.source  out_o
);

  localparam int CW   = FRACTION_BITS + 1;          // color width, holds 1.0
  localparam int NW   = (CW > FIELD_W) ? CW : FIELD_W;
  localparam int SW   = NW + 1;                     // signed step width
  localparam int SUMW = NW + 2;
  localparam int LW   = (LAYER_COUNT > 1) ? $clog2(LAYER_COUNT) : 1;

  localparam logic [CW-1:0]   ONE_C = {1'b1, {FRACTION_BITS{1'b0}}};
  localparam logic [SUMW-1:0] ONE_S = SUMW'(ONE_C);

  // latched item
  logic                mode_q;
  logic [1:0]          kind_q;
  logic                sel_all_q;
  logic [FRAMES_W-1:0] frames_q;
  logic [FIELD_W-1:0]  tgt_q [CH_COUNT];

  // layer state
  logic [CW-1:0]        color_q [LAYER_COUNT][CH_COUNT];
  logic signed [SW-1:0] step_q  [LAYER_COUNT][CH_COUNT];
  logic [NW-1:0]        goal_q  [LAYER_COUNT];
  logic [1:0]           fade_q  [LAYER_COUNT];
  logic                 vis_q   [LAYER_COUNT];

  logic [LW-1:0] ly_q;
  logic [1:0]    ch_q;
  logic          sign_q;

  logic               out_valid_q;
  logic [FIELD_W-1:0] out_col_q [2][CH_COUNT];
  logic               out_vis_q [2];

  // current element
  logic [CW-1:0]        cur_color;
  logic signed [SW-1:0] cur_step;
  logic signed [NW:0]   diff;
  logic signed [NW:0]   neg_diff;
  logic [NW-1:0]        mag;
  logic [NW-1:0]        quot;
  logic signed [SW-1:0] quot_s;
  logic signed [SW-1:0] step_new;
  logic [SUMW-1:0]      sum;
  logic [CW-1:0]        clamp_v;
  logic [NW-1:0]        alpha_w;
  logic                 done;
  logic                 vis_end;
  logic                 div_more;
  logic                 out_busy;
  logic [FRAMES_W-1:0]  divisor;
  logic [FIELD_W-1:0]   back_col [CH_COUNT];
  logic                 back_vis;

  always_comb begin
    cur_color = color_q[ly_q][ch_q];
    cur_step  = step_q[ly_q][ch_q];
    diff      = $signed({1'b0, NW'(tgt_q[ch_q])}) - $signed({1'b0, NW'(cur_color)});
    neg_diff  = -diff;
    mag       = diff[NW] ? neg_diff[NW-1:0] : diff[NW-1:0];
    quot_s    = $signed({1'b0, quot});
    step_new  = sign_q ? -quot_s : quot_s;
    divisor   = (frames_q == '0) ? FRAMES_W'(1) : frames_q;

    sum = {{(SUMW-CW){1'b0}}, cur_color} + {{(SUMW-SW){cur_step[SW-1]}}, cur_step};
    if (sum[SUMW-1]) begin
      clamp_v = '0;
    end else if (sum > ONE_S) begin
      clamp_v = ONE_C;
    end else begin
      clamp_v = sum[CW-1:0];
    end

    // end-of-fade test for the current layer
    alpha_w = NW'(color_q[ly_q][CH_ALPHA]);
    done    = 1'b0;
    vis_end = 1'b0;
    if (fade_q[ly_q] == KIND_IN) begin
      done = (alpha_w <= goal_q[ly_q]);
    end else if (fade_q[ly_q] != KIND_NONE) begin
      done    = (alpha_w >= goal_q[ly_q]);
      vis_end = (fade_q[ly_q] == KIND_STAY);
    end
  end

  tlcf_div #(
    .NW  (NW),
    .DVW (FRAMES_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (op_i == OP_DIV_LOAD),
    .step_i     (op_i == OP_DIV_STEP),
    .dividend_i (mag),
    .divisor_i  (divisor),
    .quot_o     (quot),
    .more_o     (div_more)
  );

  assign out_busy = out_valid_q && !out_o.ready;

  generate
    if (LAYER_COUNT > 1) begin : g_back
      for (genvar c = 0; c < CH_COUNT; c++) begin : g_ch
        assign back_col[c] = FIELD_W'(color_q[1][c]);
      end
      assign back_vis = vis_q[1];
    end else begin : g_no_back
      for (genvar c = 0; c < CH_COUNT; c++) begin : g_ch
        assign back_col[c] = '0;
      end
      assign back_vis = 1'b0;
    end
  endgenerate

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= 1'b0;
      kind_q      <= KIND_NONE;
      sel_all_q   <= 1'b0;
      frames_q    <= '0;
      ly_q        <= '0;
      ch_q        <= '0;
      sign_q      <= 1'b0;
      out_valid_q <= 1'b0;
      for (int l = 0; l < LAYER_COUNT; l++) begin
        for (int c = 0; c < CH_COUNT; c++) begin
          color_q[l][c] <= (c == int'(CH_ALPHA)) ? ONE_C : '0;
          step_q[l][c]  <= '0;
        end
        goal_q[l]            <= NW'(ONE_C);
        fade_q[l]            <= KIND_NONE;
        vis_q[l]             <= 1'b0;
      end
    end else begin
      // an emit in the same cycle reloads the register instead
      if (out_valid_q && out_o.ready && (op_i != OP_EMIT)) begin
        out_valid_q <= 1'b0;
      end
      case (op_i)
        OP_ACCEPT: begin
          if (in_i.valid) begin
            mode_q    <= in_i.mode;
            kind_q    <= in_i.fade_kind;
            sel_all_q <= (int'(in_i.layer_select) >= LAYER_COUNT);
            frames_q  <= in_i.frames;
            tgt_q[0]  <= in_i.target_red;
            tgt_q[1]  <= in_i.target_green;
            tgt_q[2]  <= in_i.target_blue;
            tgt_q[3]  <= in_i.target_alpha;
            ch_q      <= '0;
            if (in_i.mode && (int'(in_i.layer_select) < LAYER_COUNT)) begin
              ly_q <= LW'(in_i.layer_select);
            end else begin
              ly_q <= '0;
            end
          end
        end
        OP_BEGIN: begin
          fade_q[ly_q]            <= kind_q;
          goal_q[ly_q]            <= NW'(tgt_q[CH_ALPHA]);
          color_q[ly_q][CH_ALPHA] <= (kind_q == KIND_IN) ? ONE_C : '0;
          vis_q[ly_q]             <= 1'b1;
          ch_q                    <= '0;
        end
        OP_DIV_LOAD: begin
          sign_q <= diff[NW];
        end
        OP_DIV_STORE: begin
          step_q[ly_q][ch_q] <= step_new;
          ch_q               <= ch_q + 2'd1;
        end
        OP_CHECK: begin
          ch_q <= '0;
          if (done) begin
            fade_q[ly_q] <= KIND_NONE;
            vis_q[ly_q]  <= vis_end;
            for (int c = 0; c < CH_COUNT; c++) begin
              step_q[ly_q][c] <= '0;
            end
          end
        end
        OP_ADD: begin
          color_q[ly_q][ch_q] <= clamp_v;
          ch_q                <= ch_q + 2'd1;
        end
        OP_NEXT_LAYER: begin
          // wrap after the last layer so the index never leaves the array
          ly_q <= (ly_q == LW'(LAYER_COUNT - 1)) ? '0 : ly_q + LW'(1);
          ch_q <= '0;
        end
        OP_EMIT: begin
          if (!out_busy) begin
            out_valid_q <= 1'b1;
            for (int c = 0; c < CH_COUNT; c++) begin
              out_col_q[0][c] <= FIELD_W'(color_q[0][c]);
              out_col_q[1][c] <= back_col[c];
            end
            out_vis_q[0] <= vis_q[0];
            out_vis_q[1] <= back_vis;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    status_o.in_valid   = in_i.valid;
    status_o.is_tick    = !mode_q;
    status_o.div_more   = div_more;
    status_o.ch_more    = (ch_q != CH_LAST);
    status_o.start_more = sel_all_q && (ly_q != LW'(LAYER_COUNT - 1));
    status_o.ly_more    = (ly_q != LW'(LAYER_COUNT - 1));
    status_o.out_busy   = out_busy;
  end

  assign in_i.ready          = (op_i == OP_ACCEPT);
  assign out_o.valid         = out_valid_q;
  assign out_o.front_red     = out_col_q[0][0];
  assign out_o.front_green   = out_col_q[0][1];
  assign out_o.front_blue    = out_col_q[0][2];
  assign out_o.front_alpha   = out_col_q[0][3];
  assign out_o.back_red      = out_col_q[1][0];
  assign out_o.back_green    = out_col_q[1][1];
  assign out_o.back_blue     = out_col_q[1][2];
  assign out_o.back_alpha    = out_col_q[1][3];
  assign out_o.front_visible = out_vis_q[0];
  assign out_o.back_visible  = out_vis_q[1];

  a_layer_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(ly_q) < LAYER_COUNT)
    else $error("layer index out of range");

  a_emit_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_i == OP_EMIT && !out_busy) |=> out_valid_q)
    else $error("emit did not load the output register");

  a_alpha_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    color_q[0][CH_ALPHA] <= ONE_C)
    else $error("layer alpha above one");

endmodule

@@ rtl/tlcf_useq.sv @@
// Microcode sequencer: program counter, control store lookup and branch logic.
// Control store and types come from tlcf_pkg.
module tlcf_useq import tlcf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  seq_status_t status_i,
  output op_e         op_o
);

  logic [UPC_W-1:0] pc_q;
  logic [UPC_W-1:0] pc_d;
  uword_t           uw;
  logic             take;

  always_comb begin
    uw = ucode(pc_q);
    case (uw.cond)
      C_NEVER:      take = 1'b0;
      C_ALWAYS:     take = 1'b1;
      C_NO_VALID:   take = !status_i.in_valid;
      C_IS_TICK:    take = status_i.is_tick;
      C_DIV_MORE:   take = status_i.div_more;
      C_CH_MORE:    take = status_i.ch_more;
      C_START_MORE: take = status_i.start_more;
      C_LY_MORE:    take = status_i.ly_more;
      C_OUT_BUSY:   take = status_i.out_busy;
      default:      take = 1'b1;
    endcase
    pc_d = take ? uw.target : pc_q + UPC_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= UA_WAIT;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign op_o = uw.op;

  a_pc_in_program: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_q < UPC_W'(PROG_LEN))
    else $error("program counter left the control store");

endmodule
